### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds at every clock edge outside reset.
`define VT_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// A cause implies an effect in the same cycle.
`define VT_ASSERT_IMPLY(label, clk, rst_n, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (effect)) \
        else $error("assertion failed");

// A cause implies an effect in the following cycle.
`define VT_ASSERT_NEXT(label, clk, rst_n, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error("assertion failed");

`endif

### rtl/vt_pkg.sv
package vt_pkg;

    localparam int LANES     = 4;
    localparam int NUM_PAIRS = 8;
    localparam int ADDR_W    = 6;

    typedef logic [31:0]       q16_t;
    typedef q16_t [LANES-1:0]  q16x4_t;

    localparam q16_t ONE_Q16 = 32'h0001_0000;
    localparam q16_t Q16_MAX = 32'h7FFF_FFFF;
    localparam q16_t Q16_MIN = 32'h8000_0000;

    localparam logic [NUM_PAIRS-1:0][63:0] COEF_RESET = {
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000
    };

    typedef struct packed {
        logic en_mul;
        logic en_add;
        logic en_sum;
    } lane_ctrl_t;

    typedef struct packed {
        q16_t value;
        logic sat;
    } lane_res_t;

endpackage

### rtl/vertex_transform_4x4.sv
// Multiplies each incoming Q16.16 vector by a column-major 4x4 matrix held in eight
// 64-bit registers (identity after reset). Four row lanes each form four 32x32 products,
// add them in two register stages, shift right by sixteen and saturate; a final stage
// merges the rows and the overflow flag. One transaction is accepted every clock cycle
// unless input is blocked, passing the product, pair-sum, sum and output registers. Each
// pipeline stage holds its transaction only while the stage after it is full and stalled,
// so a stalled result blocks input only once all four stages are occupied.
module vertex_transform_4x4 (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [vt_pkg::ADDR_W-1:0]  paddr,
    input  logic [63:0]                pwdata,
    output logic [63:0]                prdata,
    output logic                       pready,
    input  logic                       vec_valid,
    output logic                       vec_ready,
    input  logic                       func,
    input  logic signed [31:0]         vx,
    input  logic signed [31:0]         vy,
    input  logic signed [31:0]         vz,
    input  logic signed [31:0]         vw,
    output logic                       res_valid,
    input  logic                       res_ready,
    output logic signed [31:0]         ox,
    output logic signed [31:0]         oy,
    output logic signed [31:0]         oz,
    output logic signed [31:0]         ow,
    output logic                       overflow
);
    import vt_pkg::*;

    logic [NUM_PAIRS-1:0][63:0] coef_pair_reg;
    logic [2:0]                 reg_index;
    logic                       cfg_write;

    logic       mul_valid_reg;
    logic       add_valid_reg;
    logic       sum_valid_reg;
    logic       res_valid_reg;
    logic       mul_point_reg;
    logic       add_point_reg;
    logic       sum_point_reg;
    logic       en_mul;
    logic       en_add;
    logic       en_sum;
    logic       en_out;
    lane_ctrl_t lane_ctrl;
    q16x4_t     vec_in;
    lane_res_t [LANES-1:0] lane_res;

    assign reg_index = paddr[ADDR_W-1:3];
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = coef_pair_reg[reg_index];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_pair_reg <= COEF_RESET;
        end
        else if (cfg_write)
        begin
            coef_pair_reg[reg_index] <= pwdata;
        end
    end

    assign en_out    = !res_valid_reg || res_ready;
    assign en_sum    = !sum_valid_reg || en_out;
    assign en_add    = !add_valid_reg || en_sum;
    assign en_mul    = !mul_valid_reg || en_add;
    assign vec_ready = en_mul;
    assign res_valid = res_valid_reg;

    assign lane_ctrl = '{en_mul: en_mul, en_add: en_add, en_sum: en_sum};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            add_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_mul)
            begin
                mul_valid_reg <= vec_valid;
            end
            if (en_add)
            begin
                add_valid_reg <= mul_valid_reg;
            end
            if (en_sum)
            begin
                sum_valid_reg <= add_valid_reg;
            end
            if (en_out)
            begin
                res_valid_reg <= sum_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_mul)
        begin
            mul_point_reg <= func;
        end
        if (en_add)
        begin
            add_point_reg <= mul_point_reg;
        end
        if (en_sum)
        begin
            sum_point_reg <= add_point_reg;
        end
    end

    assign vec_in[0] = vx;
    assign vec_in[1] = vy;
    assign vec_in[2] = vz;
    assign vec_in[3] = func ? ONE_Q16 : vw;

    for (genvar r = 0; r < LANES; r++)
    begin : g_lane
        q16x4_t lane_coef;

        for (genvar c = 0; c < LANES; c++)
        begin : g_coef
            assign lane_coef[c] = coef_pair_reg[2*c + r/2][32*(r%2) +: 32];
        end

        vt_lane u_lane (
            .clk  (clk),
            .ctrl (lane_ctrl),
            .vec  (vec_in),
            .coef (lane_coef),
            .res  (lane_res[r])
        );
    end

    vt_merge u_merge (
        .clk      (clk),
        .en       (en_out),
        .point    (sum_point_reg),
        .res      (lane_res),
        .ox       (ox),
        .oy       (oy),
        .oz       (oz),
        .ow       (ow),
        .overflow (overflow)
    );

endmodule

### rtl/vt_lane.sv
module vt_lane (
    input  logic               clk,
    input  vt_pkg::lane_ctrl_t ctrl,
    input  vt_pkg::q16x4_t     vec,
    input  vt_pkg::q16x4_t     coef,
    output vt_pkg::lane_res_t  res
);
    import vt_pkg::*;

    logic signed [63:0] prod_next [LANES];
    logic signed [63:0] prod_reg  [LANES];
    logic signed [64:0] pair_reg  [2];
    logic signed [65:0] sum_reg;
    logic signed [49:0] shifted;
    logic               out_of_range;

    always_comb
    begin
        for (int c = 0; c < LANES; c++)
        begin
            prod_next[c] = $signed(vec[c]) * $signed(coef[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en_mul)
        begin
            for (int c = 0; c < LANES; c++)
            begin
                prod_reg[c] <= prod_next[c];
            end
        end
        if (ctrl.en_add)
        begin
            pair_reg[0] <= 65'(prod_reg[0]) + 65'(prod_reg[1]);
            pair_reg[1] <= 65'(prod_reg[2]) + 65'(prod_reg[3]);
        end
        if (ctrl.en_sum)
        begin
            sum_reg <= 66'(pair_reg[0]) + 66'(pair_reg[1]);
        end
    end

    // Dropping the low sixteen bits of a two's complement value rounds towards minus infinity.
    assign shifted      = sum_reg[65:16];
    assign out_of_range = !(&shifted[49:31]) && (|shifted[49:31]);

    always_comb
    begin
        res.sat = out_of_range;
        if (out_of_range)
        begin
            res.value = shifted[49] ? Q16_MIN : Q16_MAX;
        end
        else
        begin
            res.value = shifted[31:0];
        end
    end

endmodule

### rtl/vt_merge.sv
module vt_merge (
    input  logic                              clk,
    input  logic                              en,
    input  logic                              point,
    input  vt_pkg::lane_res_t [vt_pkg::LANES-1:0] res,
    output vt_pkg::q16_t                      ox,
    output vt_pkg::q16_t                      oy,
    output vt_pkg::q16_t                      oz,
    output vt_pkg::q16_t                      ow,
    output logic                              overflow
);
    import vt_pkg::*;

    q16_t ox_reg;
    q16_t oy_reg;
    q16_t oz_reg;
    q16_t ow_reg;
    logic overflow_reg;

    // In point mode the fourth row is not part of the result.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ox_reg       <= res[0].value;
            oy_reg       <= res[1].value;
            oz_reg       <= res[2].value;
            ow_reg       <= point ? ONE_Q16 : res[3].value;
            overflow_reg <= res[0].sat || res[1].sat || res[2].sat || (!point && res[3].sat);
        end
    end

    assign ox       = ox_reg;
    assign oy       = oy_reg;
    assign oz       = oz_reg;
    assign ow       = ow_reg;
    assign overflow = overflow_reg;

endmodule

### rtl/vt_checker.sv
`include "assert_macros.svh"

module vt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pready,
    input logic        vec_valid,
    input logic        vec_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [31:0] ox,
    input logic [31:0] oy,
    input logic [31:0] oz,
    input logic [31:0] ow,
    input logic        overflow
);

    `VT_ASSERT_ALWAYS(a_pready_high, clk, rst_n, pready)

    // While results are taken every cycle, the pipeline never refuses a transaction.
    `VT_ASSERT_IMPLY(a_no_input_stall, clk, rst_n, res_ready, vec_ready)

    // A flagged result must carry at least one saturated component.
    `VT_ASSERT_IMPLY(a_overflow_saturated, clk, rst_n, res_valid && overflow,
        ox == 32'h7FFF_FFFF || ox == 32'h8000_0000 || oy == 32'h7FFF_FFFF ||
        oy == 32'h8000_0000 || oz == 32'h7FFF_FFFF || oz == 32'h8000_0000 ||
        ow == 32'h7FFF_FFFF || ow == 32'h8000_0000)

    // With the output drained, an accepted transaction reaches the output through the pipeline registers.
    `VT_ASSERT_NEXT(a_latency, clk, rst_n,
        (vec_valid && vec_ready) ##1 res_ready ##1 res_ready ##1 res_ready, res_valid)

    `VT_ASSERT_NEXT(a_result_held, clk, rst_n, res_valid && !res_ready,
        res_valid && $stable(ox) && $stable(oy) && $stable(oz) && $stable(ow) && $stable(overflow))

endmodule

bind vertex_transform_4x4 vt_checker u_vt_checker (.*);

### bench/tb_vertex_transform_4x4.sv
module tb_vertex_transform_4x4;

    localparam int AW           = vt_pkg::ADDR_W;
    localparam int PAIR_STRIDE  = 8;
    localparam int LATENCY      = 4;
    localparam int SEG_ITEMS    = 122;
    localparam int NUM_SEGS     = 9;
    localparam int NUM_DIRECTED = 18;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic signed [67:0] ROW_MAX = 68'sh7FFF_FFFF;
    localparam logic signed [67:0] ROW_MIN = -68'sh8000_0000;

    typedef enum int {
        MAT_IDENT,
        MAT_DOUBLE,
        MAT_HALF,
        MAT_SMALL,
        MAT_FULL,
        MAT_POS_EXT,
        MAT_NEG_EXT,
        MAT_ZERO
    } mat_kind_e;

    typedef logic [vt_pkg::NUM_PAIRS-1:0][63:0] pairs_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] w;
        logic        ovf;
    } vtx_t;

    typedef struct {
        mat_kind_e   mat;
        logic        pt;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] w;
        logic        typed;
        vtx_t        want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [AW-1:0] paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        vec_valid;
    logic        vec_ready;
    logic        func;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] vw;
    logic        res_valid;
    logic        res_ready;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic signed [31:0] ow;
    logic        overflow;

    logic [63:0] coef_model [vt_pkg::NUM_PAIRS];
    vtx_t        expected_verts [$];
    logic        cur_typed;
    vtx_t        cur_want;
    int          idle_pct;
    int          stall_pct;
    int          err_count;
    int          cycle_count;
    dir_row_t    directed_rows [NUM_DIRECTED];

    vertex_transform_4x4 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .vec_valid (vec_valid),
        .vec_ready (vec_ready),
        .func      (func),
        .vx        (vx),
        .vy        (vy),
        .vz        (vz),
        .vw        (vw),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .ox        (ox),
        .oy        (oy),
        .oz        (oz),
        .ow        (ow),
        .overflow  (overflow)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic signed [31:0] coef_entry(input int idx);
        logic [63:0] pair;
        pair = coef_model[idx / 2];
        return (idx % 2 == 1) ? $signed(pair[63:32]) : $signed(pair[31:0]);
    endfunction

    function automatic vtx_t transform_vertex(input logic pt, input logic [31:0] x,
                                              input logic [31:0] y, input logic [31:0] z,
                                              input logic [31:0] w);
        logic signed [31:0] v [4];
        logic signed [67:0] acc;
        logic signed [67:0] floored;
        logic [31:0]        res [4];
        vtx_t               r;
        v[0] = x;
        v[1] = y;
        v[2] = z;
        v[3] = pt ? vt_pkg::ONE_Q16 : w;
        r.ovf = 1'b0;
        for (int rr = 0; rr < 4; rr++)
        begin
            if (pt && rr == 3)
            begin
                res[rr] = vt_pkg::ONE_Q16;
            end
            else
            begin
                acc = '0;
                for (int c = 0; c < 4; c++)
                begin
                    acc = acc + v[c] * coef_entry(c * 4 + rr);
                end
                floored = acc >>> 16;
                if (floored > ROW_MAX)
                begin
                    res[rr] = vt_pkg::Q16_MAX;
                    r.ovf = 1'b1;
                end
                else if (floored < ROW_MIN)
                begin
                    res[rr] = vt_pkg::Q16_MIN;
                    r.ovf = 1'b1;
                end
                else
                begin
                    res[rr] = floored[31:0];
                end
            end
        end
        r.x = res[0];
        r.y = res[1];
        r.z = res[2];
        r.w = res[3];
        return r;
    endfunction

    function automatic logic [31:0] small_coef();
        case ($urandom_range(7))
            0: return '0;
            1: return vt_pkg::ONE_Q16;
            default: return 32'($urandom_range(0, 524288)) - 32'd262144;
        endcase
    endfunction

    function automatic logic [31:0] rand_component();
        int pick;
        pick = $urandom_range(9);
        if (pick < 6)
        begin
            return 32'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
        end
        else if (pick < 9)
        begin
            return $urandom;
        end
        case ($urandom_range(4))
            0: return vt_pkg::Q16_MAX;
            1: return vt_pkg::Q16_MIN;
            2: return '0;
            3: return '1;
            default: return 32'd1;
        endcase
    endfunction

    function automatic pairs_t build_matrix(input mat_kind_e kind);
        pairs_t p;
        p = '0;
        case (kind)
            MAT_IDENT:
                p = vt_pkg::COEF_RESET;
            MAT_DOUBLE:
            begin
                p[0] = 64'h0000_0000_0002_0000;
                p[2] = 64'h0002_0000_0000_0000;
                p[5] = 64'h0000_0000_0002_0000;
                p[7] = 64'h0002_0000_0000_0000;
            end
            MAT_HALF:
            begin
                p[0] = 64'h0000_0000_0000_8000;
                p[2] = 64'h0000_8000_0000_0000;
                p[5] = 64'h0000_0000_0000_8000;
                p[7] = 64'h0000_8000_0000_0000;
            end
            MAT_SMALL:
                for (int i = 0; i < vt_pkg::NUM_PAIRS; i++)
                begin
                    p[i] = {small_coef(), small_coef()};
                end
            MAT_FULL:
                for (int i = 0; i < vt_pkg::NUM_PAIRS; i++)
                begin
                    p[i] = {$urandom, $urandom};
                end
            MAT_POS_EXT:
                p = {vt_pkg::NUM_PAIRS{64'h7FFF_FFFF_7FFF_FFFF}};
            MAT_NEG_EXT:
                p = {vt_pkg::NUM_PAIRS{64'h8000_0000_8000_0000}};
            default:
                p = '0;
        endcase
        return p;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            err_count++;
        end
    endtask

    task automatic write_coef_pair(input int idx, input logic [63:0] val);
        logic [63:0] readback;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = AW'(idx * PAIR_STRIDE);
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        readback = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        coef_model[idx] = val;
        if (readback !== val)
        begin
            $display("%0t: coef_pair_%0d read expected %h, got %h", $time, idx, val, readback);
            err_count++;
        end
    endtask

    task automatic load_matrix(input pairs_t p);
        for (int i = 0; i < vt_pkg::NUM_PAIRS; i++)
        begin
            write_coef_pair(i, p[i]);
        end
    endtask

    task automatic wait_results_drained();
        vec_valid = 1'b0;
        while (expected_verts.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_vertex(input logic pt, input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z, input logic [31:0] w,
                               input logic typed, input vtx_t want);
        while ($urandom_range(99) < idle_pct)
        begin
            vec_valid = 1'b0;
            @(negedge clk);
        end
        vec_valid = 1'b1;
        func      = pt;
        vx        = x;
        vy        = y;
        vz        = z;
        vw        = w;
        cur_typed = typed;
        cur_want  = want;
        @(posedge clk);
        while (!vec_ready) @(posedge clk);
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        res_ready = ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        vtx_t want;
        if (rst_n && vec_valid && vec_ready)
        begin
            expected_verts.push_back(cur_typed ? cur_want
                                               : transform_vertex(func, vx, vy, vz, vw));
        end
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_verts.size() == 0)
            begin
                $display("%0t: result expected none, got %h %h %h %h %b",
                         $time, ox, oy, oz, ow, overflow);
                err_count++;
            end
            else
            begin
                want = expected_verts.pop_front();
                check_field("ox", want.x, ox);
                check_field("oy", want.y, oy);
                check_field("oz", want.z, oz);
                check_field("ow", want.w, ow);
                check_field("overflow", 32'(want.ovf), 32'(overflow));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[vertex_transform_4x4] ERROR");
            $finish;
        end
    end

    initial
    begin
        mat_kind_e cur_mat;
        mat_kind_e seg_mats [NUM_SEGS];
        int        seg_idle [4];
        int        seg_stall [4];
        clk         = 1'b0;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        vec_valid   = 1'b0;
        res_ready   = 1'b0;
        func        = 1'b0;
        vx          = '0;
        vy          = '0;
        vz          = '0;
        vw          = '0;
        cur_typed   = 1'b0;
        cur_want    = '0;
        idle_pct    = 0;
        stall_pct   = 0;
        err_count   = 0;
        cycle_count = 0;
        for (int i = 0; i < vt_pkg::NUM_PAIRS; i++)
        begin
            coef_model[i] = vt_pkg::COEF_RESET[i];
        end
        seg_mats  = '{MAT_SMALL, MAT_POS_EXT, MAT_SMALL, MAT_NEG_EXT, MAT_FULL,
                      MAT_SMALL, MAT_ZERO, MAT_IDENT, MAT_SMALL};
        seg_idle  = '{0, 64, 0, 13};
        seg_stall = '{0, 0, 64, 13};

        directed_rows = '{
            '{MAT_IDENT, 1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
              1'b1, '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0}},
            '{MAT_IDENT, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
              1'b1, '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0}},
            '{MAT_IDENT, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'hFFFF_0000,
              1'b1, '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'hFFFF_0000, 1'b0}},
            '{MAT_IDENT, 1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 32'h1234_5678, 32'hEDCB_A988,
              1'b1, '{32'hAAAA_AAAA, 32'h5555_5555, 32'h1234_5678, 32'hEDCB_A988, 1'b0}},
            '{MAT_IDENT, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hDEAD_BEEF,
              1'b1, '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0001_0000, 1'b0}},
            '{MAT_IDENT, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
              1'b1, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000, 1'b0}},
            '{MAT_IDENT, 1'b0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000,
              1'b1, '{32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0}},
            '{MAT_DOUBLE, 1'b0, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
              1'b1, '{32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1}},
            '{MAT_DOUBLE, 1'b0, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
              1'b1, '{32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1}},
            '{MAT_DOUBLE, 1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h4000_0000,
              1'b1, '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1}},
            '{MAT_DOUBLE, 1'b0, 32'h3FFF_FFFF, 32'hC000_0000, 32'h0000_8000, 32'hFFFF_FFFF,
              1'b1, '{32'h7FFF_FFFE, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_FFFE, 1'b0}},
            '{MAT_DOUBLE, 1'b0, 32'h4000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
              1'b1, '{32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1}},
            '{MAT_DOUBLE, 1'b1, 32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 32'h7FFF_FFFF,
              1'b1, '{32'h0002_0000, 32'h0004_0000, 32'h0000_0000, 32'h0001_0000, 1'b0}},
            '{MAT_DOUBLE, 1'b1, 32'h0000_0000, 32'h0000_0000, 32'hC000_0000, 32'h0000_0000,
              1'b1, '{32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h0001_0000, 1'b0}},
            '{MAT_DOUBLE, 1'b1, 32'h0000_0000, 32'hBFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
              1'b1, '{32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0001_0000, 1'b1}},
            '{MAT_HALF, 1'b0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0003, 32'hFFFF_FFFD,
              1'b1, '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE, 1'b0}},
            '{MAT_HALF, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678,
              1'b1, '{32'hC000_0000, 32'h3FFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000, 1'b0}},
            '{MAT_HALF, 1'b0, 32'h0001_8001, 32'hFFFE_7FFF, 32'h7FFF_0001, 32'h8000_FFFF,
              1'b0, '0}
        };

        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // The first rows run against the identity matrix left by reset.
        cur_mat = MAT_IDENT;
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            if (directed_rows[i].mat != cur_mat)
            begin
                wait_results_drained();
                cur_mat = directed_rows[i].mat;
                load_matrix(build_matrix(cur_mat));
            end
            send_vertex(directed_rows[i].pt, directed_rows[i].x, directed_rows[i].y,
                        directed_rows[i].z, directed_rows[i].w,
                        directed_rows[i].typed, directed_rows[i].want);
        end

        for (int s = 0; s < NUM_SEGS; s++)
        begin
            wait_results_drained();
            load_matrix(build_matrix(seg_mats[s]));
            idle_pct  = seg_idle[s % 4];
            stall_pct = seg_stall[s % 4];
            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                send_vertex(1'($urandom_range(1)), rand_component(), rand_component(),
                            rand_component(), rand_component(), 1'b0, '0);
            end
        end

        wait_results_drained();
        stall_pct = 0;
        repeat (2 * LATENCY) @(posedge clk);
        if (err_count == 0)
        begin
            $display("[vertex_transform_4x4] OK");
        end
        else
        begin
            $display("[vertex_transform_4x4] ERROR");
        end
        $finish;
    end

endmodule
